// ----- hdl/tcw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Item kinds as they arrive on the command port
  localparam logic [2:0] KIND_PUT_CUR = 3'd0;
  localparam logic [2:0] KIND_PUT_POS = 3'd1;
  localparam logic [2:0] KIND_ERASE   = 3'd2;
  localparam logic [2:0] KIND_CLEAR   = 3'd3;
  localparam logic [2:0] KIND_READ    = 3'd4;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_ERROR   = 8'd69;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_code;
    logic [6:0] column;
    logic [4:0] row_index;
  } cmd_t;

  typedef struct packed {
    logic [10:0] cursor_cell;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic        error;
    logic        scrolled;
  } result_t;

  // Classified operation handed from the front to the back
  typedef enum logic [2:0] {
    OP_PUT_CUR,
    OP_PUT_POS,
    OP_PUT_ERR,
    OP_ERASE,
    OP_CLEAR,
    OP_READ,
    OP_READ_ERR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [6:0] column;
    logic [4:0] row_index;
  } entry_t;

  typedef struct packed {
    logic [7:0] normal_attr;
    logic [7:0] error_attr;
  } attr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/tcw_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tcw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_front
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic   start,
  input  wire cmd_t   cmd,
  input  wire logic   full,
  output logic        busy,
  output logic        push,
  output entry_t      entry
);

  logic onscreen;

  assign busy     = full;
  assign push     = start && !full;
  assign onscreen = ({1'b0, cmd.column} < 8'(COLS)) && ({1'b0, cmd.row_index} < 6'(ROWS));

  always_comb begin
    entry.char_code = cmd.char_code;
    entry.column    = cmd.column;
    entry.row_index = cmd.row_index;
    unique case (cmd.kind)
      KIND_PUT_CUR: entry.op = OP_PUT_CUR;
      KIND_PUT_POS: entry.op = onscreen ? OP_PUT_POS : OP_PUT_ERR;
      KIND_ERASE:   entry.op = OP_ERASE;
      KIND_CLEAR:   entry.op = OP_CLEAR;
      KIND_READ:    entry.op = onscreen ? OP_READ : OP_READ_ERR;
      default:      entry.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/tcw_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_fifo
  import tcw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t wdata,
  input  wire logic   pop,
  output entry_t      rdata,
  output logic        valid,
  output logic        full
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  entry_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign rdata = slots[rd_ptr];
  assign valid = (count != '0);
  assign full  = (count == NW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tcw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire attr_t  attr,
  input  wire logic   q_valid,
  input  wire entry_t q_entry,
  output logic        pop,
  output logic        done,
  output result_t     result
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);

  state_t        state, state_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [AW-1:0] idx, idx_next;
  logic [15:0]   fill_val, fill_val_next;
  result_t       res_next;
  logic          done_next;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;

  logic [RW-1:0] pos_row, put_row, er_row;
  logic [CW-1:0] pos_col, put_col, er_col;
  logic          put_scroll;
  logic          at_home;

  function automatic logic [AW-1:0] cell_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
    cell_of = AW'(AW'(r) * AW'(COLS)) + AW'(c);
  endfunction

  tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_cells (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Target cell of a put and the cursor it leaves behind, and the cell an erase steps back to
  always_comb begin
    pos_row    = (q_entry.op == OP_PUT_CUR) ? cur_row : q_entry.row_index[RW-1:0];
    pos_col    = (q_entry.op == OP_PUT_CUR) ? cur_col : q_entry.column[CW-1:0];
    put_scroll = 1'b0;
    put_row    = pos_row;
    put_col    = pos_col + 1'b1;
    if (q_entry.char_code == CH_NEWLINE || pos_col == CW'(COLS - 1)) begin
      put_col = '0;
      if (pos_row == RW'(ROWS - 1)) begin
        put_scroll = 1'b1;
      end else begin
        put_row = pos_row + 1'b1;
      end
    end
    at_home = (cur_row == '0) && (cur_col == '0);
    if (cur_col == '0) begin
      er_row = cur_row - 1'b1;
      er_col = CW'(COLS - 1);
    end else begin
      er_row = cur_row;
      er_col = cur_col - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          priority if ((q_entry.op == OP_PUT_CUR || q_entry.op == OP_PUT_POS) && put_scroll)
            state_next = ST_SCR_RD;
          else if (q_entry.op == OP_CLEAR)
            state_next = ST_FILL;
          else if (q_entry.op == OP_READ)
            state_next = ST_READ;
          else
            state_next = ST_IDLE;
        end
      end
      ST_READ:   state_next = ST_IDLE;
      ST_SCR_RD: state_next = ST_SCR_WR;
      ST_SCR_WR: state_next = (idx == AW'(CELLS - COLS - 1)) ? ST_FILL : ST_SCR_RD;
      ST_FILL:   state_next = (idx == AW'(CELLS - 1)) ? ST_IDLE : ST_FILL;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = idx;
    wr_data       = fill_val;
    rd_en         = 1'b0;
    rd_addr       = idx + AW'(COLS);
    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    idx_next      = idx;
    fill_val_next = fill_val;
    res_next      = result;
    done_next     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          pop                  = 1'b1;
          done_next            = 1'b1;
          res_next             = '0;
          res_next.cursor_cell = 11'(cell_of(cur_row, cur_col));
          unique case (q_entry.op)
            OP_PUT_CUR, OP_PUT_POS: begin
              if (q_entry.char_code != CH_NEWLINE) begin
                wr_en   = 1'b1;
                wr_addr = cell_of(pos_row, pos_col);
                wr_data = {attr.normal_attr, q_entry.char_code};
              end
              cur_row_next         = put_row;
              cur_col_next         = put_col;
              res_next.cursor_cell = 11'(cell_of(put_row, put_col));
              if (put_scroll) begin
                res_next.scrolled = 1'b1;
                done_next         = 1'b0;
                idx_next          = '0;
                fill_val_next     = '0;
              end
            end
            OP_PUT_ERR: begin
              wr_en          = 1'b1;
              wr_addr        = AW'(CELLS - 1);
              wr_data        = {attr.error_attr, CH_ERROR};
              res_next.error = 1'b1;
            end
            OP_ERASE: begin
              if (!at_home) begin
                wr_en                = 1'b1;
                wr_addr              = cell_of(er_row, er_col);
                wr_data              = {attr.normal_attr, CH_SPACE};
                cur_row_next         = er_row;
                cur_col_next         = er_col;
                res_next.cursor_cell = 11'(cell_of(er_row, er_col));
              end
            end
            OP_CLEAR: begin
              done_next            = 1'b0;
              idx_next             = '0;
              fill_val_next        = {attr.normal_attr, CH_SPACE};
              cur_row_next         = '0;
              cur_col_next         = '0;
              res_next.cursor_cell = '0;
            end
            OP_READ: begin
              rd_en     = 1'b1;
              rd_addr   = cell_of(pos_row, pos_col);
              done_next = 1'b0;
            end
            OP_READ_ERR: res_next.error = 1'b1;
            OP_NOP: ;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_next.read_char = rd_data[7:0];
        res_next.read_attr = rd_data[15:8];
        done_next          = 1'b1;
      end
      ST_SCR_RD: begin
        rd_en = 1'b1;
      end
      ST_SCR_WR: begin
        wr_en    = 1'b1;
        wr_data  = rd_data;
        idx_next = idx + 1'b1;
      end
      ST_FILL: begin
        wr_en    = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == AW'(CELLS - 1)) begin
          done_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cur_row <= '0;
      cur_col <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    fill_val <= fill_val_next;
    result   <= res_next;
  end

endmodule

`default_nettype wire

// ----- hdl/text_console_writer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel     Ports                          Handshake
// ----------  -----------------------------  -------------------------------------
// command     start, busy, cmd (cmd_t)       item taken when start && !busy
// result      done, result (result_t)        item shown for one cycle while done
// config      psel penable pwrite paddr      written when psel && penable && pwrite
//             pwdata prdata pready           (pready tied high), 0: normal, 4: error
//
// An ordinary item's result is registered as the back end takes it from the
// queue; a read of a cell adds the ST_READ state for the registered port of the
// cell store. An item that scrolls the screen walks the store cell by cell: it
// reads each cell below the top row (ST_SCR_RD) and writes it one row up
// (ST_SCR_WR), then writes each cell of the last row (ST_FILL). Clear writes
// one cell a cycle. A two-entry queue lets commands arrive while the back end
// works; busy rises when it is full. Reset homes the cursor and loads the
// attribute registers; the cell store is left as it is. The result side
// cannot stall.

module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire cmd_t        cmd,
  output logic             done,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_NORMAL_ATTR = 1'b0;
  localparam logic REG_ERROR_ATTR  = 1'b1;

  attr_t  attr;
  logic   push;
  logic   full;
  entry_t entry;
  entry_t q_entry;
  logic   q_valid;
  logic   pop;

  assign pready = 1'b1;

  // Attribute registers; only bit 2 of the address selects among them
  always_ff @(posedge clk) begin
    if (rst) begin
      attr.normal_attr <= 8'd15;
      attr.error_attr  <= 8'd244;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_NORMAL_ATTR: attr.normal_attr <= pwdata[7:0];
        REG_ERROR_ATTR:  attr.error_attr  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NORMAL_ATTR: prdata = {24'd0, attr.normal_attr};
      REG_ERROR_ATTR:  prdata = {24'd0, attr.error_attr};
      default:         prdata = '0;
    endcase
  end

  // Classify commands and hand them to the queue
  tcw_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
    .start (start),
    .cmd   (cmd),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .entry (entry)
  );

  tcw_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .pop   (pop),
    .rdata (q_entry),
    .valid (q_valid),
    .full  (full)
  );

  // Execute against the cell store and the cursor
  tcw_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .attr    (attr),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule

`default_nettype wire
